>>> src/selection_set_manager_top_defines.svh
// ----------------------------------------------------------------------------
// Selection set manager assertion macros
// Assertion wrappers used by the selection set sequencer.
// ----------------------------------------------------------------------------
`ifndef SELECTION_SET_MANAGER_TOP_DEFINES_SVH
`define SELECTION_SET_MANAGER_TOP_DEFINES_SVH

`ifndef SYNTH
`define SSM_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("selection set manager: invariant violated");
`define SSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("selection set manager: sequence violated");
`else
`define SSM_ASSERT_ALWAYS(lbl, expr)
`define SSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/ssm_pkg.sv
// ----------------------------------------------------------------------------
// Selection set manager package
// Sizes, command codes, sequencer states and shared structures.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int SET_CAPACITY = 64;
    localparam int SLOT_BITS    = 12;
    localparam int POS_BITS     = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int COUNT_BITS   = $clog2(SET_CAPACITY + 1);

    localparam int CMD_W         = 3;
    localparam int SLOT_FIELD_W  = 12;
    localparam int RPOS_FIELD_W  = 6;
    localparam int COUNT_FIELD_W = 7;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_TOGGLE = 3'd3,
        CMD_QUERY  = 3'd4,
        CMD_READ   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_READ,
        ST_CLEAR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                     was_member;
        logic                     mark_valid;
        logic [SLOT_FIELD_W-1:0]  mark_slot;
        logic                     mark_value;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic [SLOT_FIELD_W-1:0]  read_value;
        logic                     read_valid;
        logic                     rejected_full;
        logic                     last;
    } res_t;

    typedef struct packed {
        logic                 we;
        logic [POS_BITS-1:0]  waddr;
        logic [SLOT_BITS-1:0] wdata;
        logic [POS_BITS-1:0]  raddr;
    } mem_req_t;

endpackage

>>> src/selection_set_manager_top.sv
// ----------------------------------------------------------------------------
// Selection set manager
// Ordered set of up to SET_CAPACITY distinct slot numbers driven by a
// stream of clear, add, remove, toggle, query and read requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is ready again once the last
// result of that request is in the output register. Add, remove, toggle
// and query search the entry memory one position per cycle through a
// single comparator; a remove that hits stops searching at the match and
// then compacts the later entries one move per cycle. A read returns the
// entry at the read position when the position is below the count. A clear
// reports each dropped entry in turn, and a clear of an empty set or an
// unused command gives a single result. A stalled result stream holds the
// sequencer until the output register drains. The entry memory is not
// cleared after reset and entries beyond the count never reach a result.
module selection_set_manager_top
    import ssm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // slot_number[11:0], read_position[17:12], zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]    s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // was_member[0], mark_slot[12:1], mark_value[13], entry_count[20:14],
    // read_value[32:21], rejected_full[33], zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // mark_valid[0], read_valid[1]
    output logic [M_USER_W-1:0] m_axis_tuser,
    output logic                m_axis_tlast
);

    mem_req_t             req;
    logic [SLOT_BITS-1:0] key;
    logic [SLOT_BITS-1:0] rdata;
    logic                 match;
    logic                 push;
    logic                 push_ready;
    res_t                 push_res;
    res_t                 out_res;

    ssm_store u_store (
        .clk   (clk),
        .req   (req),
        .key   (key),
        .rdata (rdata),
        .match (match)
    );

    ssm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_slot    (s_axis_tdata[SLOT_FIELD_W-1:0]),
        .in_rpos    (s_axis_tdata[SLOT_FIELD_W +: RPOS_FIELD_W]),
        .req        (req),
        .key        (key),
        .rdata      (rdata),
        .match      (match),
        .push       (push),
        .push_res   (push_res),
        .push_ready (push_ready)
    );

    ssm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_res   (push_res),
        .push_ready (push_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    assign m_axis_tdata = {6'b0,
                           out_res.rejected_full,
                           out_res.read_value,
                           out_res.entry_count,
                           out_res.mark_value,
                           out_res.mark_slot,
                           out_res.was_member};
    assign m_axis_tuser = {out_res.read_valid, out_res.mark_valid};
    assign m_axis_tlast = out_res.last;

endmodule

>>> src/ssm_store.sv
// ----------------------------------------------------------------------------
// Selection set entry store
// Entry memory with one write and one registered read port, and the shared
// comparator that matches the read entry against the search key.
// ----------------------------------------------------------------------------
module ssm_store
    import ssm_pkg::*;
(
    input  logic                 clk,
    input  mem_req_t             req,
    input  logic [SLOT_BITS-1:0] key,
    output logic [SLOT_BITS-1:0] rdata,
    output logic                 match
);

    logic [SLOT_BITS-1:0] mem [SET_CAPACITY];
    logic [SLOT_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
    assign match = (rdata_reg == key);

endmodule

>>> src/ssm_out_buf.sv
// ----------------------------------------------------------------------------
// Selection set result register
// One-deep output register that decouples the sequencer from the result
// stream.
// ----------------------------------------------------------------------------
module ssm_out_buf
    import ssm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic push_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic full_reg;
    logic full_next;
    res_t data_reg;

    assign push_ready = !full_reg || out_ready;

    always_comb
    begin
        full_next = full_reg;
        if (push && push_ready)
        begin
            full_next = 1'b1;
        end
        else if (out_ready)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            data_reg <= push_res;
        end
    end

    assign out_valid = full_reg;
    assign out_res   = data_reg;

endmodule

>>> src/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// Selection set sequencer
// Steps through the entry store one position per cycle to search, compact,
// read and drain the set (the drain can stall), and builds the results.
// ----------------------------------------------------------------------------
`include "selection_set_manager_top_defines.svh"

module ssm_ctrl
    import ssm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W-1:0]        in_cmd,
    input  logic [SLOT_FIELD_W-1:0] in_slot,
    input  logic [RPOS_FIELD_W-1:0] in_rpos,
    output mem_req_t                req,
    output logic [SLOT_BITS-1:0]    key,
    input  logic [SLOT_BITS-1:0]    rdata,
    input  logic                    match,
    output logic                    push,
    output res_t                    push_res,
    input  logic                    push_ready
);

    localparam int CMP_W = COUNT_BITS + RPOS_FIELD_W;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] limit_reg, limit_next;
    logic [POS_BITS-1:0]  idx_reg, idx_next;
    logic                 found_reg, found_next;
    res_t                 res_reg, res_next;

    logic [COUNT_BITS-1:0] idx_plus1;
    logic [COUNT_BITS-1:0] idx_plus2;
    logic                  clr_last;
    logic                  is_add;
    logic                  is_rem;
    cmd_t                  in_cmd_e;

    assign idx_plus1 = COUNT_BITS'(idx_reg) + COUNT_BITS'(1);
    assign idx_plus2 = COUNT_BITS'(idx_reg) + COUNT_BITS'(2);
    assign clr_last  = (idx_plus1 == limit_reg);
    assign is_add    = (cmd_reg == CMD_ADD) || ((cmd_reg == CMD_TOGGLE) && !found_reg);
    assign is_rem    = (cmd_reg == CMD_REMOVE) || ((cmd_reg == CMD_TOGGLE) && found_reg);
    assign in_cmd_e  = cmd_t'(in_cmd);
    assign key       = slot_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        limit_next = limit_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        res_next   = res_reg;
        req.we     = 1'b0;
        req.waddr  = idx_reg;
        req.wdata  = slot_reg;
        req.raddr  = idx_reg;
        push       = 1'b0;
        push_res   = res_reg;
        in_ready   = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                req.raddr = '0;
                if (in_valid)
                begin
                    cmd_next   = in_cmd_e;
                    slot_next  = SLOT_BITS'(in_slot);
                    idx_next   = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    res_next.entry_count = COUNT_FIELD_W'(count_reg);
                    res_next.last        = 1'b1;
                    unique case (in_cmd_e)
                        CMD_CLEAR:
                        begin
                            limit_next = count_reg;
                            count_next = '0;
                            res_next.entry_count = '0;
                            state_next = (count_reg == '0) ? ST_EMIT : ST_CLEAR;
                        end
                        CMD_ADD, CMD_REMOVE, CMD_TOGGLE, CMD_QUERY:
                        begin
                            state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                        end
                        CMD_READ:
                        begin
                            req.raddr = POS_BITS'(in_rpos);
                            if (CMP_W'(in_rpos) < CMP_W'(count_reg))
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                req.raddr = POS_BITS'(idx_plus1);
                if (match)
                begin
                    found_next = 1'b1;
                    state_next = ST_DECIDE;
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = POS_BITS'(idx_plus1);
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_EMIT;
                if (is_add)
                begin
                    res_next.was_member = found_reg;
                    if (count_reg >= COUNT_BITS'(SET_CAPACITY))
                    begin
                        res_next.rejected_full = 1'b1;
                    end
                    else if (!found_reg)
                    begin
                        req.we     = 1'b1;
                        req.waddr  = POS_BITS'(count_reg);
                        count_next = count_reg + COUNT_BITS'(1);
                        res_next.mark_valid  = 1'b1;
                        res_next.mark_slot   = SLOT_FIELD_W'(slot_reg);
                        res_next.mark_value  = 1'b1;
                        res_next.entry_count = COUNT_FIELD_W'(count_reg + COUNT_BITS'(1));
                    end
                end
                else if (is_rem)
                begin
                    if (found_reg)
                    begin
                        if (idx_plus1 < count_reg)
                        begin
                            req.raddr  = POS_BITS'(idx_plus1);
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - COUNT_BITS'(1);
                            res_next.was_member  = 1'b1;
                            res_next.mark_valid  = 1'b1;
                            res_next.mark_slot   = SLOT_FIELD_W'(slot_reg);
                            res_next.entry_count = COUNT_FIELD_W'(count_reg - COUNT_BITS'(1));
                        end
                    end
                end
                else
                begin
                    res_next.was_member = found_reg;
                end
            end

            ST_SHIFT:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = rdata;
                req.raddr = POS_BITS'(idx_plus2);
                if (idx_plus2 < count_reg)
                begin
                    idx_next = POS_BITS'(idx_plus1);
                end
                else
                begin
                    count_next = count_reg - COUNT_BITS'(1);
                    res_next.was_member  = 1'b1;
                    res_next.mark_valid  = 1'b1;
                    res_next.mark_slot   = SLOT_FIELD_W'(slot_reg);
                    res_next.entry_count = COUNT_FIELD_W'(count_reg - COUNT_BITS'(1));
                    state_next = ST_EMIT;
                end
            end

            ST_READ:
            begin
                res_next.read_value = SLOT_FIELD_W'(rdata);
                res_next.read_valid = 1'b1;
                state_next = ST_EMIT;
            end

            ST_CLEAR:
            begin
                push       = 1'b1;
                push_res   = '0;
                push_res.was_member = 1'b1;
                push_res.mark_valid = 1'b1;
                push_res.mark_slot  = SLOT_FIELD_W'(rdata);
                push_res.last       = clr_last;
                if (push_ready)
                begin
                    if (clr_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = POS_BITS'(idx_plus1);
                        req.raddr = POS_BITS'(idx_plus1);
                    end
                end
            end

            ST_EMIT:
            begin
                push = 1'b1;
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        slot_reg  <= slot_next;
        limit_reg <= limit_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        res_reg   <= res_next;
    end

    `SSM_ASSERT_ALWAYS(a_count_in_range, count_reg <= COUNT_BITS'(SET_CAPACITY))
    `SSM_ASSERT_ALWAYS(a_shift_in_set, (state_reg != ST_SHIFT) || (idx_plus2 <= count_reg))
    `SSM_ASSERT_ALWAYS(a_clear_drained, (state_reg != ST_CLEAR) || ((count_reg == '0) && (idx_plus1 <= limit_reg)))
    `SSM_ASSERT_NEXT(a_clear_ends, (state_reg == ST_CLEAR) && push_ready && clr_last, state_reg == ST_IDLE)

endmodule
